// ===== rtl/core/accel_self_test_offset_calibrator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the self-test offset calibrator
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ACCEL_SELF_TEST_OFFSET_CALIBRATOR_ASSERT_SVH
`define ACCEL_SELF_TEST_OFFSET_CALIBRATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ASTOC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASTOC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/astoc_pkg.sv =====
// ----------------------------------------------------------------------------
// Self-test offset calibrator package
// Types, codes and helper functions shared by controller and datapath.
// ----------------------------------------------------------------------------
package astoc_pkg;

	localparam int unsigned SAMPLES = 40;

	// divide by 40: (|s| * 52429) >> 21, exact for |s| < 2^18
	localparam logic [16:0] DIV_MULT  = 17'd52429;
	localparam int unsigned DIV_SHIFT = 21;

	localparam logic [2:0] DIV_LAST  = 3'd5;
	localparam logic [2:0] DIV_DRAIN = 3'd6;

	localparam logic CFG_SETTLE_OFF = 1'b0;
	localparam logic CFG_SETTLE_ON  = 1'b1;

	localparam logic [7:0] SETTLE_OFF_RST = 8'd40;
	localparam logic [7:0] SETTLE_ON_RST  = 8'd4;

	localparam logic signed [11:0] X_LO = 12'sd11;
	localparam logic signed [11:0] X_HI = 12'sd118;
	localparam logic signed [11:0] Y_LO = -12'sd118;
	localparam logic signed [11:0] Y_HI = -12'sd11;
	localparam logic signed [11:0] Z_LO = 12'sd15;
	localparam logic signed [11:0] Z_HI = 12'sd161;
	localparam logic signed [11:0] Z_BIAS = 12'sd64;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_SETTLE_OFF = 3'd1,
		PH_AVG_OFF    = 3'd2,
		PH_SETTLE_ON  = 3'd3,
		PH_AVG_ON     = 3'd4,
		PH_DONE       = 3'd5
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETTLE_OFF,
		ST_AVG_OFF,
		ST_SETTLE_ON,
		ST_AVG_ON,
		ST_DIVIDE,
		ST_CHECK,
		ST_PUBLISH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       clear;
		logic       cnt_inc;
		logic       cnt_clr;
		logic       acc_off;
		logic       acc_on;
		logic       div_issue;
		logic [2:0] div_sel;
		logic       chk_en;
		logic       load_out;
		phase_t     out_phase;
	} dp_cmd_t;

	typedef struct packed {
		logic settle_off_zero;
		logic settle_on_zero;
		logic reach_settle_off;
		logic reach_settle_on;
		logic reach_avg;
	} dp_sts_t;

	function automatic phase_t state_phase(input state_t st);
		phase_t ph;
		unique case (st)
			ST_IDLE:       ph = PH_IDLE;
			ST_SETTLE_OFF: ph = PH_SETTLE_OFF;
			ST_AVG_OFF:    ph = PH_AVG_OFF;
			ST_SETTLE_ON:  ph = PH_SETTLE_ON;
			ST_AVG_ON:     ph = PH_AVG_ON;
			ST_DIVIDE,
			ST_CHECK,
			ST_PUBLISH,
			ST_DONE:       ph = PH_DONE;
		endcase
		return ph;
	endfunction

	function automatic logic signed [7:0] sat8(input logic signed [11:0] v);
		logic signed [7:0] r;
		if (v > 12'sd127) begin
			r = 8'sd127;
		end else if (v < -12'sd128) begin
			r = -8'sd128;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/accel_self_test_offset_calibrator.sv =====
// ----------------------------------------------------------------------------
// Accelerometer self-test and offset calibrator
// Every accepted word (a start command or a sample triple) yields one result
// word with the run phase, pass flags and int8 offsets. A word is taken
// while the result register is free or being read. The word that completes
// the self-test-on average triggers a finish sequence: six divides by 40
// through one shared multiplier, a drain step, the window check and the
// publish step, which waits while the result register is held; input stalls
// meanwhile.
// ----------------------------------------------------------------------------
module accel_self_test_offset_calibrator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cmd,
	input  logic signed [9:0] x_sample,
	input  logic signed [9:0] y_sample,
	input  logic signed [9:0] z_sample,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        phase,
	output logic              request_self_test,
	output logic              done_res,
	output logic              x_pass,
	output logic              y_pass,
	output logic              z_pass,
	output logic              all_pass,
	output logic signed [7:0] x_offset,
	output logic signed [7:0] y_offset,
	output logic signed [7:0] z_offset,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data
);

	astoc_pkg::dp_cmd_t dp_cmd;
	astoc_pkg::dp_sts_t dp_sts;

	astoc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_cmd    (dp_cmd),
		.dp_sts    (dp_sts)
	);

	astoc_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.x_sample          (x_sample),
		.y_sample          (y_sample),
		.z_sample          (z_sample),
		.dp_cmd            (dp_cmd),
		.dp_sts            (dp_sts),
		.phase             (phase),
		.request_self_test (request_self_test),
		.done_res          (done_res),
		.x_pass            (x_pass),
		.y_pass            (y_pass),
		.z_pass            (z_pass),
		.all_pass          (all_pass),
		.x_offset          (x_offset),
		.y_offset          (y_offset),
		.z_offset          (z_offset)
	);

endmodule

// ===== rtl/core/astoc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Calibrator controller
// Run sequencer, input/output handshake and divide/check sequencing.
// ----------------------------------------------------------------------------
`include "accel_self_test_offset_calibrator_assert.svh"

module astoc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	output logic               out_valid,
	input  logic               out_stall,
	output astoc_pkg::dp_cmd_t dp_cmd,
	input  astoc_pkg::dp_sts_t dp_sts
);

	astoc_pkg::state_t state_q, state_d;
	logic [2:0] div_idx_q;
	logic       out_valid_q;
	logic       busy;
	logic       out_free;
	logic       acc;

	assign busy      = (state_q == astoc_pkg::ST_DIVIDE) || (state_q == astoc_pkg::ST_CHECK) ||
	                   (state_q == astoc_pkg::ST_PUBLISH);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = busy || !out_free;
	assign acc       = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		if (acc && cmd) begin
			state_d = dp_sts.settle_off_zero ? astoc_pkg::ST_AVG_OFF : astoc_pkg::ST_SETTLE_OFF;
		end else begin
			unique case (state_q)
				astoc_pkg::ST_IDLE: begin
				end
				astoc_pkg::ST_SETTLE_OFF: begin
					if (acc && dp_sts.reach_settle_off) state_d = astoc_pkg::ST_AVG_OFF;
				end
				astoc_pkg::ST_AVG_OFF: begin
					if (acc && dp_sts.reach_avg) begin
						state_d = dp_sts.settle_on_zero ? astoc_pkg::ST_AVG_ON
						                                : astoc_pkg::ST_SETTLE_ON;
					end
				end
				astoc_pkg::ST_SETTLE_ON: begin
					if (acc && dp_sts.reach_settle_on) state_d = astoc_pkg::ST_AVG_ON;
				end
				astoc_pkg::ST_AVG_ON: begin
					if (acc && dp_sts.reach_avg) state_d = astoc_pkg::ST_DIVIDE;
				end
				astoc_pkg::ST_DIVIDE: begin
					if (div_idx_q == astoc_pkg::DIV_DRAIN) state_d = astoc_pkg::ST_CHECK;
				end
				astoc_pkg::ST_CHECK: begin
					state_d = astoc_pkg::ST_PUBLISH;
				end
				astoc_pkg::ST_PUBLISH: begin
					if (out_free) state_d = astoc_pkg::ST_DONE;
				end
				astoc_pkg::ST_DONE: begin
				end
			endcase
		end
	end

	always_comb begin
		dp_cmd           = '0;
		dp_cmd.out_phase = astoc_pkg::state_phase(state_d);
		dp_cmd.div_sel   = div_idx_q;
		if (acc && cmd) begin
			dp_cmd.clear    = 1'b1;
			dp_cmd.cnt_clr  = 1'b1;
			dp_cmd.load_out = 1'b1;
		end else if (acc) begin
			unique case (state_q)
				astoc_pkg::ST_SETTLE_OFF: begin
					dp_cmd.cnt_inc = 1'b1;
					dp_cmd.cnt_clr = dp_sts.reach_settle_off;
				end
				astoc_pkg::ST_AVG_OFF: begin
					dp_cmd.acc_off = 1'b1;
					dp_cmd.cnt_inc = 1'b1;
					dp_cmd.cnt_clr = dp_sts.reach_avg;
				end
				astoc_pkg::ST_SETTLE_ON: begin
					dp_cmd.cnt_inc = 1'b1;
					dp_cmd.cnt_clr = dp_sts.reach_settle_on;
				end
				astoc_pkg::ST_AVG_ON: begin
					dp_cmd.acc_on  = 1'b1;
					dp_cmd.cnt_inc = 1'b1;
					dp_cmd.cnt_clr = dp_sts.reach_avg;
				end
				astoc_pkg::ST_IDLE,
				astoc_pkg::ST_DIVIDE,
				astoc_pkg::ST_CHECK,
				astoc_pkg::ST_PUBLISH,
				astoc_pkg::ST_DONE: begin
				end
			endcase
			// the final averaging word reports only after the check
			dp_cmd.load_out = !((state_q == astoc_pkg::ST_AVG_ON) && dp_sts.reach_avg);
		end else begin
			unique case (state_q)
				astoc_pkg::ST_DIVIDE: begin
					dp_cmd.div_issue = (div_idx_q <= astoc_pkg::DIV_LAST);
				end
				astoc_pkg::ST_CHECK: begin
					dp_cmd.chk_en = 1'b1;
				end
				astoc_pkg::ST_PUBLISH: begin
					dp_cmd.load_out  = out_free;
					dp_cmd.out_phase = astoc_pkg::PH_DONE;
				end
				astoc_pkg::ST_IDLE,
				astoc_pkg::ST_SETTLE_OFF,
				astoc_pkg::ST_AVG_OFF,
				astoc_pkg::ST_SETTLE_ON,
				astoc_pkg::ST_AVG_ON,
				astoc_pkg::ST_DONE: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= astoc_pkg::ST_IDLE;
			div_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == astoc_pkg::ST_DIVIDE && div_idx_q != astoc_pkg::DIV_DRAIN) begin
				div_idx_q <= div_idx_q + 3'd1;
			end else begin
				div_idx_q <= '0;
			end
			if (dp_cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASTOC_ASSERT_SAME(a_load_free, dp_cmd.load_out, out_free, "result word overwritten")
	`ASTOC_ASSERT_SAME(a_idx_idle, state_q != astoc_pkg::ST_DIVIDE, div_idx_q == 3'd0, "stray index")
	`ASTOC_ASSERT_SAME(a_busy_stall, busy, in_stall, "input word taken while busy")
	`ASTOC_ASSERT_NEXT(a_load_valid, dp_cmd.load_out, out_valid_q, "result word not raised")

endmodule

// ===== rtl/core/astoc_dp.sv =====
// ----------------------------------------------------------------------------
// Calibrator datapath
// Config registers, sample counter, sums, shared divide-by-40, window check,
// offset saturation and result word register.
// ----------------------------------------------------------------------------
module astoc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic signed [9:0]   x_sample,
	input  logic signed [9:0]   y_sample,
	input  logic signed [9:0]   z_sample,
	input  astoc_pkg::dp_cmd_t  dp_cmd,
	output astoc_pkg::dp_sts_t  dp_sts,
	output logic [2:0]          phase,
	output logic                request_self_test,
	output logic                done_res,
	output logic                x_pass,
	output logic                y_pass,
	output logic                z_pass,
	output logic                all_pass,
	output logic signed [7:0]   x_offset,
	output logic signed [7:0]   y_offset,
	output logic signed [7:0]   z_offset
);

	logic [7:0]         settle_off_q, settle_on_q;
	logic [7:0]         cnt_q;
	logic [7:0]         cnt_inc;
	logic signed [15:0] off_sum_q [3];
	logic signed [15:0] on_sum_q  [3];
	logic signed [15:0] smp_ext   [3];
	logic signed [10:0] avg_q     [6];
	logic signed [15:0] div_op;
	logic [16:0]        div_ext, div_mag;
	logic [33:0]        prod_s1;
	logic               neg_s1, vld_s1;
	logic [2:0]         sel_s1;
	logic [9:0]         quo;
	logic signed [10:0] quo_s;
	logic signed [11:0] diff      [3];
	logic signed [11:0] twice     [3];
	logic [3:0]         flags_q;
	logic signed [7:0]  offs_q    [3];
	logic [3:0]         flags_c;
	logic signed [7:0]  offs_c    [3];
	astoc_pkg::phase_t  out_phase_q;
	logic [3:0]         out_flags_q;
	logic signed [7:0]  out_offs_q [3];

	assign smp_ext[0] = {{6{x_sample[9]}}, x_sample};
	assign smp_ext[1] = {{6{y_sample[9]}}, y_sample};
	assign smp_ext[2] = {{6{z_sample[9]}}, z_sample};

	assign cnt_inc = cnt_q + 8'd1;
	assign dp_sts.settle_off_zero  = (settle_off_q == 8'd0);
	assign dp_sts.settle_on_zero   = (settle_on_q == 8'd0);
	assign dp_sts.reach_settle_off = (cnt_inc >= settle_off_q);
	assign dp_sts.reach_settle_on  = (cnt_inc >= settle_on_q);
	assign dp_sts.reach_avg        = (cnt_inc >= 8'(astoc_pkg::SAMPLES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_off_q <= astoc_pkg::SETTLE_OFF_RST;
			settle_on_q  <= astoc_pkg::SETTLE_ON_RST;
			cnt_q        <= '0;
			flags_q      <= '0;
			vld_s1       <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				off_sum_q[i] <= '0;
				on_sum_q[i]  <= '0;
				offs_q[i]    <= '0;
			end
		end else begin
			if (cfg_we && cfg_index == astoc_pkg::CFG_SETTLE_OFF) settle_off_q <= cfg_data;
			if (cfg_we && cfg_index == astoc_pkg::CFG_SETTLE_ON)  settle_on_q  <= cfg_data;
			if (dp_cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (dp_cmd.cnt_inc) begin
				cnt_q <= cnt_inc;
			end
			vld_s1 <= dp_cmd.div_issue;
			if (dp_cmd.clear) begin
				flags_q <= '0;
			end else if (dp_cmd.chk_en) begin
				flags_q <= flags_c;
			end
			for (int i = 0; i < 3; i++) begin
				if (dp_cmd.clear) begin
					off_sum_q[i] <= '0;
					on_sum_q[i]  <= '0;
					offs_q[i]    <= '0;
				end else begin
					if (dp_cmd.acc_off) off_sum_q[i] <= off_sum_q[i] + smp_ext[i];
					if (dp_cmd.acc_on)  on_sum_q[i]  <= on_sum_q[i] + smp_ext[i];
					if (dp_cmd.chk_en)  offs_q[i]    <= offs_c[i];
				end
			end
		end
	end

	// shared divide by 40, one operand per cycle, truncation toward zero
	always_comb begin
		unique case (dp_cmd.div_sel)
			3'd0:    div_op = off_sum_q[0];
			3'd1:    div_op = off_sum_q[1];
			3'd2:    div_op = off_sum_q[2];
			3'd3:    div_op = on_sum_q[0];
			3'd4:    div_op = on_sum_q[1];
			3'd5:    div_op = on_sum_q[2];
			default: div_op = '0;
		endcase
	end

	assign div_ext = {div_op[15], div_op};
	assign div_mag = div_op[15] ? (~div_ext + 17'd1) : div_ext;
	assign quo     = prod_s1[astoc_pkg::DIV_SHIFT +: 10];
	assign quo_s   = neg_s1 ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

	always_ff @(posedge clk) begin
		if (dp_cmd.div_issue) begin
			prod_s1 <= 34'(div_mag) * 34'(astoc_pkg::DIV_MULT);
			neg_s1  <= div_op[15];
			sel_s1  <= dp_cmd.div_sel;
		end
		if (vld_s1) begin
			for (int i = 0; i < 6; i++) begin
				if (sel_s1 == 3'(i)) avg_q[i] <= quo_s;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i]  = {avg_q[i + 3][10], avg_q[i + 3]} - {avg_q[i][10], avg_q[i]};
			twice[i] = {avg_q[i], 1'b0};
		end
		flags_c[0] = (diff[0] >= astoc_pkg::X_LO) && (diff[0] <= astoc_pkg::X_HI);
		flags_c[1] = (diff[1] >= astoc_pkg::Y_LO) && (diff[1] <= astoc_pkg::Y_HI);
		flags_c[2] = (diff[2] >= astoc_pkg::Z_LO) && (diff[2] <= astoc_pkg::Z_HI);
		flags_c[3] = &flags_c[2:0];
		if (flags_c[3]) begin
			offs_c[0] = astoc_pkg::sat8(-twice[0]);
			offs_c[1] = astoc_pkg::sat8(-twice[1]);
			offs_c[2] = astoc_pkg::sat8(astoc_pkg::Z_BIAS - twice[2]);
		end else begin
			offs_c[0] = '0;
			offs_c[1] = '0;
			offs_c[2] = '0;
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (dp_cmd.load_out) begin
			out_phase_q <= dp_cmd.out_phase;
			out_flags_q <= dp_cmd.clear ? 4'd0 : flags_q;
			for (int i = 0; i < 3; i++) begin
				out_offs_q[i] <= dp_cmd.clear ? 8'sd0 : offs_q[i];
			end
		end
	end

	assign phase             = out_phase_q;
	assign request_self_test = (out_phase_q == astoc_pkg::PH_SETTLE_ON) ||
	                           (out_phase_q == astoc_pkg::PH_AVG_ON);
	assign done_res          = (out_phase_q == astoc_pkg::PH_DONE);
	assign x_pass            = out_flags_q[0];
	assign y_pass            = out_flags_q[1];
	assign z_pass            = out_flags_q[2];
	assign all_pass          = out_flags_q[3];
	assign x_offset          = out_offs_q[0];
	assign y_offset          = out_offs_q[1];
	assign z_offset          = out_offs_q[2];

endmodule
